FILE: rtl/tsli_pkg.sv
// shared types and constants of the two-axis stepper line interpolator
package tsli_pkg;

  // item operation codes
  localparam logic [1:0] FUNC_LINE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_ZERO = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_STEPS_PER_MM = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_STEPS_PER_MM = 1'd1;

  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_DATA_BITS-1:0] X_STEPS_PER_MM_RST = 16'd26597;
  localparam logic [CFG_DATA_BITS-1:0] Y_STEPS_PER_MM_RST = 16'd15876;

  // steps-per-mm fraction bits
  localparam int unsigned RATE_FRAC = 12;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               limit_x;
    logic               limit_y;
  } in_item_t;

  typedef struct packed {
    logic               step_x;
    logic               dir_x;
    logic               step_y;
    logic               dir_y;
    logic               busy_res;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } out_item_t;

  typedef struct packed {
    logic stage_valid;
  } front_stat_t;

  typedef struct packed {
    logic fire;
  } back_stat_t;

endpackage

FILE: rtl/tsli_front.sv
// front end: accepts items, scales targets to whole steps, pushes into the queue
module tsli_front
  import tsli_pkg::*;
#(
  parameter int POS_BITS         = 16,
  parameter int TARGET_FRAC_BITS = 6,
  parameter int ENTRY_W          = 2 * 16 + 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_item,
  input  logic [CFG_DATA_BITS-1:0] spm_x,
  input  logic [CFG_DATA_BITS-1:0] spm_y,
  output logic                     push,
  output logic [ENTRY_W-1:0]       push_data,
  input  logic                     push_full,
  output front_stat_t              stat
);

  localparam int SH  = TARGET_FRAC_BITS + RATE_FRAC;
  localparam int MW  = 33;
  localparam int SW  = MW + 1;
  localparam int RW  = SW - SH;
  localparam int CW  = ((RW > POS_BITS) ? RW : POS_BITS) + 1;

  logic            f_valid_r, f_valid_nxt;
  logic [1:0]      func_r;
  logic            lim_r;
  logic [MW-1:0]   mag_x_r, mag_y_r;
  logic            neg_x_r, neg_y_r;
  logic [16:0]     abs_x, abs_y;
  logic            accept, advance;
  logic [POS_BITS-1:0] ts_x, ts_y;

  // magnitude of a target times rate, rounded half away, saturated, sign restored
  function automatic logic [POS_BITS-1:0] to_steps(input logic [MW-1:0] mag,
                                                   input logic neg);
    logic [SW-1:0] sum;
    logic [CW-1:0] r;
    logic [CW-1:0] lim;
    logic [CW-1:0] rc;
    logic [POS_BITS-1:0] rp;
    sum = {1'b0, mag} + (SW'(1) << (SH - 1));
    r   = CW'(sum[SW-1:SH]);
    lim = CW'(1) << (POS_BITS - 1);
    if (!neg) begin
      rc = (r > (lim - CW'(1))) ? (lim - CW'(1)) : r;
    end else begin
      rc = (r > lim) ? lim : r;
    end
    rp = rc[POS_BITS-1:0];
    return neg ? -rp : rp;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign advance  = f_valid_r && !push_full;
  assign in_stall = f_valid_r && push_full;

  assign abs_x = in_item.target_x[15] ? -{in_item.target_x[15], in_item.target_x}
                                      : {1'b0, in_item.target_x};
  assign abs_y = in_item.target_y[15] ? -{in_item.target_y[15], in_item.target_y}
                                      : {1'b0, in_item.target_y};

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (advance) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    if (accept) begin
      func_r  <= in_item.func;
      lim_r   <= in_item.limit_x | in_item.limit_y;
      mag_x_r <= MW'(abs_x) * MW'(spm_x);
      mag_y_r <= MW'(abs_y) * MW'(spm_y);
      neg_x_r <= in_item.target_x[15];
      neg_y_r <= in_item.target_y[15];
    end
  end

  assign ts_x      = to_steps(mag_x_r, neg_x_r);
  assign ts_y      = to_steps(mag_y_r, neg_y_r);
  assign push      = advance;
  assign push_data = {func_r, ts_x, ts_y, lim_r};
  assign stat.stage_valid = f_valid_r;

endmodule

FILE: rtl/tsli_queue.sv
// short queue between the front end and the motion back end
module tsli_queue #(
  parameter int DATA_W = 35,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + PW'(1));
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CW'(count_r + CW'(1));
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/tsli_back.sv
// back end: line state, incremental slope test, back-off and result register
module tsli_back
  import tsli_pkg::*;
#(
  parameter int POS_BITS = 16,
  parameter int ENTRY_W  = 2 * 16 + 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  output back_stat_t         stat
);

  localparam int P  = POS_BITS;
  localparam int EW = POS_BITS + 3;

  logic [P-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [P-1:0]  span_maj_r, span_maj_nxt, span_min_r, span_min_nxt;
  logic [P-1:0]  done_r, done_nxt;
  logic [EW-1:0] err_r, err_nxt;
  logic          fwd_x_r, fwd_x_nxt, fwd_y_r, fwd_y_nxt;
  logic          x_major_r, x_major_nxt;
  logic          running_r, running_nxt;
  logic [1:0]    backoff_r, backoff_nxt;
  logic          out_valid_r;
  out_item_t     out_r, out_nxt;
  logic          fire;

  logic [1:0]    func;
  logic [P-1:0]  ts_x, ts_y;
  logic          lim;
  logic [P:0]    ex, ey, nex, ney;
  logic [P-1:0]  sp_x, sp_y;
  logic          sx, sy, dx, dy;
  logic [EW-1:0] e1;
  logic          minor_step;

  assign func = q_data[ENTRY_W-1 -: 2];
  assign ts_x = q_data[2*P:P+1];
  assign ts_y = q_data[P:1];
  assign lim  = q_data[0];

  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;

  // start of a line: error to target and spans
  assign ex   = {ts_x[P-1], ts_x} - {pos_x_r[P-1], pos_x_r};
  assign ey   = {ts_y[P-1], ts_y} - {pos_y_r[P-1], pos_y_r};
  assign nex  = -ex;
  assign ney  = -ey;
  assign sp_x = ex[P] ? nex[P-1:0] : ex[P-1:0];
  assign sp_y = ey[P] ? ney[P-1:0] : ey[P-1:0];

  // error term is 2*minor*done_major - (2*done_minor+1)*major, kept by adds
  assign e1 = err_r + EW'({span_min_r, 1'b0});
  assign minor_step = (span_min_r != '0) && !e1[EW-1] && (e1 != '0);

  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    span_maj_nxt = span_maj_r;
    span_min_nxt = span_min_r;
    done_nxt     = done_r;
    err_nxt      = err_r;
    fwd_x_nxt    = fwd_x_r;
    fwd_y_nxt    = fwd_y_r;
    x_major_nxt  = x_major_r;
    running_nxt  = running_r;
    backoff_nxt  = backoff_r;
    sx = 1'b0;
    sy = 1'b0;
    dx = fwd_x_r;
    dy = fwd_y_r;

    unique case (func)
      FUNC_LINE: begin
        if (!running_r && backoff_r == 2'd0) begin
          fwd_x_nxt    = !ex[P];
          fwd_y_nxt    = !ey[P];
          x_major_nxt  = sp_x > sp_y;
          span_maj_nxt = (sp_x > sp_y) ? sp_x : sp_y;
          span_min_nxt = (sp_x > sp_y) ? sp_y : sp_x;
          done_nxt     = '0;
          err_nxt      = -EW'((sp_x > sp_y) ? sp_x : sp_y);
          running_nxt  = ((sp_x > sp_y) ? sp_x : sp_y) != '0;
          dx = !ex[P];
          dy = !ey[P];
        end
      end
      FUNC_TICK: begin
        if (running_r && lim) begin
          running_nxt = 1'b0;
          backoff_nxt = 2'd2;
        end
        if (running_r && lim || backoff_r != 2'd0) begin
          // back-off step against the direction of travel on both axes
          pos_x_nxt   = fwd_x_r ? P'(pos_x_r - P'(1)) : P'(pos_x_r + P'(1));
          pos_y_nxt   = fwd_y_r ? P'(pos_y_r - P'(1)) : P'(pos_y_r + P'(1));
          sx = 1'b1;
          sy = 1'b1;
          dx = !fwd_x_r;
          dy = !fwd_y_r;
          backoff_nxt = (running_r && lim) ? 2'd1 : 2'(backoff_r - 2'd1);
        end else if (running_r) begin
          done_nxt = P'(done_r + P'(1));
          err_nxt  = minor_step ? EW'(e1 - EW'({span_maj_r, 1'b0})) : e1;
          if (x_major_r) begin
            sx = 1'b1;
            sy = minor_step;
          end else begin
            sy = 1'b1;
            sx = minor_step;
          end
          if (sx) begin
            pos_x_nxt = fwd_x_r ? P'(pos_x_r + P'(1)) : P'(pos_x_r - P'(1));
          end
          if (sy) begin
            pos_y_nxt = fwd_y_r ? P'(pos_y_r + P'(1)) : P'(pos_y_r - P'(1));
          end
          if (({1'b0, done_r} + (P+1)'(1)) >= {1'b0, span_maj_r}) begin
            running_nxt = 1'b0;
          end
        end
      end
      FUNC_ZERO: begin
        pos_x_nxt = '0;
        pos_y_nxt = '0;
      end
      default: begin
      end
    endcase

    out_nxt.step_x   = sx;
    out_nxt.dir_x    = dx;
    out_nxt.step_y   = sy;
    out_nxt.dir_y    = dy;
    out_nxt.busy_res = running_nxt || (backoff_nxt != 2'd0);
    out_nxt.pos_x    = 16'(pos_x_nxt);
    out_nxt.pos_y    = 16'(pos_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      span_maj_r  <= '0;
      span_min_r  <= '0;
      done_r      <= '0;
      err_r       <= '0;
      fwd_x_r     <= 1'b1;
      fwd_y_r     <= 1'b1;
      x_major_r   <= 1'b0;
      running_r   <= 1'b0;
      backoff_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        pos_x_r    <= pos_x_nxt;
        pos_y_r    <= pos_y_nxt;
        span_maj_r <= span_maj_nxt;
        span_min_r <= span_min_nxt;
        done_r     <= done_nxt;
        err_r      <= err_nxt;
        fwd_x_r    <= fwd_x_nxt;
        fwd_y_r    <= fwd_y_nxt;
        x_major_r  <= x_major_nxt;
        running_r  <= running_nxt;
        backoff_r  <= backoff_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign stat.fire = fire;

endmodule

FILE: rtl/two_axis_stepper_line_interpolator.sv
// top level of the two-axis stepper line interpolator
//
// Takes one item per clock unless input stalls and returns one result item per
// item, in order. A line item, when idle, rounds its X/Y target (fixed-point
// mm) to whole steps with the steps-per-mm registers and starts a line from the
// current position; a tick during a line steps the major axis once and the
// minor axis when the slope test holds; a limit seen on a tick during a line
// ends it and backs off two steps on both axes; a zero item clears both
// positions. The front end registers the two target-times-rate products, then
// rounds and saturates them into a two-entry queue; the back end pops one item
// a cycle unless output stalls, updates the line state with an add-only error
// term (the exact integer form of the cross-multiplied slope test) and loads
// the result register. Sustained rate is one item per cycle without output
// stalls; items pass the product, queue and result registers. A stalled result
// register fills the queue and then the front stage before input stalls.
// Configuration writes are taken at any time but are meant for idle periods.
module two_axis_stepper_line_interpolator
  import tsli_pkg::*;
#(
  parameter int POS_BITS         = 16,
  parameter int TARGET_FRAC_BITS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_item,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // queue entry: func, target x steps, target y steps, limit seen
  localparam int ENTRY_W = 2 * POS_BITS + 3;

  logic [CFG_DATA_BITS-1:0] spm_x_r, spm_y_r;
  logic                     q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0]       q_push_data, q_data;
  front_stat_t              fr_stat;
  back_stat_t               bk_stat;

  // steps-per-mm registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_x_r <= X_STEPS_PER_MM_RST;
      spm_y_r <= Y_STEPS_PER_MM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_STEPS_PER_MM: spm_x_r <= cfg_wdata;
        CFG_Y_STEPS_PER_MM: spm_y_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // front end: scale and round targets
  tsli_front #(
    .POS_BITS         (POS_BITS),
    .TARGET_FRAC_BITS (TARGET_FRAC_BITS),
    .ENTRY_W          (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .spm_x     (spm_x_r),
    .spm_y     (spm_y_r),
    .push      (q_push),
    .push_data (q_push_data),
    .push_full (q_full),
    .stat      (fr_stat)
  );

  // decoupling queue
  tsli_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  // back end: motion state and result register
  tsli_back #(
    .POS_BITS (POS_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .stat      (bk_stat)
  );

  // an accepted item always sits in the front stage on the next cycle
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> fr_stat.stage_valid)
    else $error("accepted item missing from front stage");

  // every back-end update yields a valid result
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.fire |=> out_valid)
    else $error("back-end update produced no result");

  // a held result changes only through a back-end update
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !bk_stat.fire) |=> $stable(out_item))
    else $error("result changed without an update");

endmodule
